// ----- rtl/dvad_pkg.sv -----
// Package: widths, payload words, codes and month tables for the date adder.
`default_nettype none
package dvad_pkg;

  localparam int unsigned OffsetBits = 16;
  localparam int unsigned DayW       = OffsetBits + 1;
  localparam int unsigned YrW        = ((OffsetBits > 19) ? (OffsetBits - 7) : 12) + 2;
  localparam int unsigned YearW      = 12;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 12;

  localparam logic [2:0] StatOk       = 3'd0;
  localparam logic [2:0] StatYearLim  = 3'd1;
  localparam logic [2:0] StatBadDay   = 3'd2;
  localparam logic [2:0] StatBadMonth = 3'd3;
  localparam logic [2:0] StatPastEnd  = 3'd4;
  localparam logic [2:0] StatNotLeap  = 3'd5;
  localparam logic [2:0] StatOutRange = 3'd6;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinYear    = 3'd0,
    CfgMaxYear    = 3'd1,
    CfgTodayDay   = 3'd2,
    CfgTodayMonth = 3'd3,
    CfgTodayYear  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [4:0]                   day_in;
    logic [3:0]                   month_in;
    logic [YearW-1:0]             year_in;
    logic signed [OffsetBits-1:0] day_offset;
  } in_t;

  typedef struct packed {
    logic [4:0]       day_out;
    logic [3:0]       month_out;
    logic [YearW-1:0] year_out;
    logic [2:0]       status;
  } out_t;

  typedef struct packed {
    logic [YearW-1:0] min_year;
    logic [YearW-1:0] max_year;
    logic [4:0]       today_day;
    logic [3:0]       today_month;
    logic [YearW-1:0] today_year;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic reduce;
    logic check;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic rem_done;
    logic bad;
    logic settled;
  } sts_t;

  localparam logic [4:0] MonthDays [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [4:0] MonthMaxDays [12] = '{
    5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // rem is the year modulo 400
  function automatic logic leap_of(input logic [11:0] rem);
    logic div4;
    logic div100;
    begin
      div4   = (rem[1:0] == 2'b00);
      div100 = (rem == 12'd100) || (rem == 12'd200) || (rem == 12'd300);
      leap_of = (div4 && !div100) || (rem == 12'd0);
    end
  endfunction

  // mon must be 1..12
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [3:0] idx;
    begin
      idx = mon - 4'd1;
      if (mon == 4'd2 && leap) begin
        month_len = 5'd29;
      end else if (idx < 4'd12) begin
        month_len = MonthDays[idx];
      end else begin
        month_len = MonthDays[0];
      end
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/dvad_cfg.sv -----
// Configuration registers: year limits and the current date.
`default_nettype none
module dvad_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [dvad_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [dvad_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output dvad_pkg::cfg_t                      cfg_o
);

  dvad_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dvad_pkg::CfgMinYear:    cfg_d.min_year    = cfg_wdata_i[11:0];
        dvad_pkg::CfgMaxYear:    cfg_d.max_year    = cfg_wdata_i[11:0];
        dvad_pkg::CfgTodayDay:   cfg_d.today_day   = cfg_wdata_i[4:0];
        dvad_pkg::CfgTodayMonth: cfg_d.today_month = cfg_wdata_i[3:0];
        dvad_pkg::CfgTodayYear:  cfg_d.today_year  = cfg_wdata_i[11:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_year    <= 12'd1902;
      cfg_q.max_year    <= 12'd2037;
      cfg_q.today_day   <= 5'd1;
      cfg_q.today_month <= 4'd1;
      cfg_q.today_year  <= 12'd2000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ----- rtl/dvad_ctrl.sv -----
// Sequencer: load, year reduction, date check, month stepping, result strobe.
`default_nettype none
module dvad_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire dvad_pkg::sts_t sts_i,
  output dvad_pkg::cmd_t     cmd_o,
  output logic               busy_o,
  output logic               valid_o
);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StReduce = 5'b00010,
    StCheck  = 5'b00100,
    StStep   = 5'b01000,
    StDone   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StReduce;
        end
      end
      StReduce: begin
        cmd_o.reduce = 1'b1;
        if (sts_i.rem_done) state_d = StCheck;
      end
      StCheck: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.bad ? StDone : StStep;
      end
      StStep: begin
        cmd_o.step = 1'b1;
        if (sts_i.settled) state_d = StDone;
      end
      StDone: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o  = (state_q != StIdle);
  assign valid_o = (state_q == StDone);

endmodule
`default_nettype wire

// ----- rtl/dvad_dp.sv -----
// Datapath: operand registers, year mod 400 tracking, date check, month stepper.
`default_nettype none
module dvad_dp (
  input  wire logic            clk_i,
  input  wire dvad_pkg::in_t   in_i,
  input  wire dvad_pkg::cfg_t  cfg_i,
  input  wire dvad_pkg::cmd_t  cmd_i,
  output dvad_pkg::sts_t       sts_o,
  output dvad_pkg::out_t       out_o
);

  localparam int unsigned DayW = dvad_pkg::DayW;
  localparam int unsigned YrW  = dvad_pkg::YrW;
  localparam int unsigned OffW = dvad_pkg::OffsetBits;

  logic [4:0]                    d_q, d_d;
  logic [3:0]                    mon_q, mon_d;
  logic signed [YrW-1:0]         yr_q, yr_d;
  logic signed [OffW-1:0]        off_q, off_d;
  logic [11:0]                   rem_q, rem_d;
  logic signed [DayW-1:0]        day_q, day_d;
  dvad_pkg::out_t                out_q, out_d;

  logic                          leap_c, leap_p;
  logic [3:0]                    mon_p, mon_n;
  logic [11:0]                   rem_p, rem_n;
  logic [4:0]                    len_c, len_p;
  logic signed [DayW-1:0]        len_c_s, len_p_s;
  logic                          day_le0, day_gt;
  logic [2:0]                    chk;
  logic [3:0]                    midx;
  logic signed [YrW-1:0]         min_s, max_s;
  logic                          in_range;

  always_comb begin
    leap_c  = dvad_pkg::leap_of(rem_q);
    mon_p   = (mon_q == 4'd1) ? 4'd12 : mon_q - 4'd1;
    rem_p   = (mon_q != 4'd1) ? rem_q : ((rem_q == 12'd0) ? 12'd399 : rem_q - 12'd1);
    leap_p  = dvad_pkg::leap_of(rem_p);
    mon_n   = (mon_q == 4'd12) ? 4'd1 : mon_q + 4'd1;
    rem_n   = (mon_q != 4'd12) ? rem_q : ((rem_q == 12'd399) ? 12'd0 : rem_q + 12'd1);
    len_c   = dvad_pkg::month_len(mon_q, leap_c);
    len_p   = dvad_pkg::month_len(mon_p, leap_p);
    len_c_s = $signed({{(DayW-5){1'b0}}, len_c});
    len_p_s = $signed({{(DayW-5){1'b0}}, len_p});
    day_le0 = day_q[DayW-1] || (day_q == '0);
    day_gt  = day_q > len_c_s;
    min_s   = $signed({{(YrW-12){1'b0}}, cfg_i.min_year});
    max_s   = $signed({{(YrW-12){1'b0}}, cfg_i.max_year});
    in_range = (yr_q >= min_s) && (yr_q <= max_s);
    midx    = mon_q - 4'd1;

    priority if (!in_range) begin
      chk = dvad_pkg::StatYearLim;
    end else if (d_q == 5'd0) begin
      chk = dvad_pkg::StatBadDay;
    end else if (mon_q == 4'd0 || mon_q > 4'd12) begin
      chk = dvad_pkg::StatBadMonth;
    end else if (dvad_pkg::MonthMaxDays[midx] < d_q) begin
      chk = dvad_pkg::StatPastEnd;
    end else if (mon_q == 4'd2 && d_q == 5'd29 && !leap_c) begin
      chk = dvad_pkg::StatNotLeap;
    end else begin
      chk = dvad_pkg::StatOk;
    end
  end

  always_comb begin
    d_d   = d_q;
    mon_d = mon_q;
    yr_d  = yr_q;
    off_d = off_q;
    rem_d = rem_q;
    day_d = day_q;
    out_d = out_q;
    if (cmd_i.load) begin
      d_d   = (in_i.day_in == 5'd0) ? cfg_i.today_day : in_i.day_in;
      mon_d = (in_i.month_in == 4'd0) ? cfg_i.today_month : in_i.month_in;
      rem_d = (in_i.year_in == 12'd0) ? cfg_i.today_year : in_i.year_in;
      yr_d  = $signed({{(YrW-12){1'b0}}, rem_d});
      off_d = in_i.day_offset;
    end
    if (cmd_i.reduce && rem_q >= 12'd400) begin
      rem_d = rem_q - 12'd400;
    end
    if (cmd_i.check) begin
      day_d = $signed({{(DayW-5){1'b0}}, d_q}) + DayW'(off_q);
      if (chk != dvad_pkg::StatOk) begin
        out_d        = '0;
        out_d.status = chk;
      end
    end
    if (cmd_i.step) begin
      if (day_le0) begin
        mon_d = mon_p;
        rem_d = rem_p;
        yr_d  = (mon_q == 4'd1) ? yr_q - YrW'(1) : yr_q;
        day_d = day_q + len_p_s;
      end else if (day_gt) begin
        mon_d = mon_n;
        rem_d = rem_n;
        yr_d  = (mon_q == 4'd12) ? yr_q + YrW'(1) : yr_q;
        day_d = day_q - len_c_s;
      end else if (in_range) begin
        out_d.day_out   = day_q[4:0];
        out_d.month_out = mon_q;
        out_d.year_out  = yr_q[11:0];
        out_d.status    = dvad_pkg::StatOk;
      end else begin
        out_d        = '0;
        out_d.status = dvad_pkg::StatOutRange;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    mon_q <= mon_d;
    yr_q  <= yr_d;
    off_q <= off_d;
    rem_q <= rem_d;
    day_q <= day_d;
    out_q <= out_d;
  end

  assign sts_o.rem_done = (rem_q < 12'd400);
  assign sts_o.bad      = (chk != dvad_pkg::StatOk);
  assign sts_o.settled  = !day_le0 && !day_gt;
  assign out_o          = out_q;

endmodule
`default_nettype wire

// ----- rtl/date_validate_and_add_days.sv -----
// Top level: Gregorian date check and signed day offset.
// An item is taken when start_i is high while busy_o is low; busy_o stays high until
// the result word shows on out_o with valid_o for exactly one cycle, and it cannot be
// held off. The year is reduced modulo 400 by one subtract a cycle, and the month
// stepper walks one month per cycle over each month boundary the offset crosses.
// A rejected date skips the stepper. Configuration writes are taken at any time but
// are meant for idle periods.
`default_nettype none
module date_validate_and_add_days (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire dvad_pkg::in_t                  in_i,
  output logic                                valid_o,
  output dvad_pkg::out_t                      out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [dvad_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [dvad_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  dvad_pkg::cfg_t cfg;
  dvad_pkg::cmd_t cmd;
  dvad_pkg::sts_t sts;
  logic           busy;

  dvad_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dvad_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i && !busy),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .valid_o (valid_o)
  );

  dvad_dp u_dp (
    .clk_i (clk_i),
    .in_i  (in_i),
    .cfg_i (cfg),
    .cmd_i (cmd),
    .sts_o (sts),
    .out_o (out_o)
  );

  assign busy_o = busy;

endmodule
`default_nettype wire

// ----- rtl/dvad_checker.sv -----
// Port-level checker for the date adder, bound to the top level.
`default_nettype none
module dvad_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            start_i,
  input wire logic            busy_o,
  input wire logic            valid_o,
  input wire dvad_pkg::out_t  out_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not raise busy");

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("result strobe while idle");

  a_valid_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> (!valid_o && !busy_o))
    else $error("result strobe not followed by idle");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && out_o.status != dvad_pkg::StatOk) |->
      (out_o.day_out == 5'd0 && out_o.month_out == 4'd0 && out_o.year_out == 12'd0))
    else $error("error result carries a date");

  a_ok_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && out_o.status == dvad_pkg::StatOk) |->
      (out_o.day_out != 5'd0 && out_o.month_out != 4'd0 && out_o.month_out <= 4'd12))
    else $error("good result with an impossible date");

endmodule

bind date_validate_and_add_days dvad_checker u_dvad_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .valid_o (valid_o),
  .out_o   (out_o)
);
`default_nettype wire

// ----- test/date_result_checker.sv -----
// Checker: predicts each date word's result from the observed writes and inputs, then compares.
module date_result_checker
  import dvad_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_o,
  input  in_t                 in_i,
  input  logic                valid_o,
  input  out_t                out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  errors,
  output int                  pending,
  output int                  checked
);

  cfg_t cfg;
  out_t expected_q[$];
  out_t want;

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in(input int mon, input int y);
    int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (mon == 2 && leap_year(y)) begin
      return 29;
    end
    return lens[mon - 1];
  endfunction

  function automatic out_t date_result(input in_t w, input cfg_t c);
    int lens_max[12] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int d, m, y, off, lo, hi, day, mon, yr;
    logic [2:0] st;
    out_t r;
    r   = '0;
    lo  = c.min_year;
    hi  = c.max_year;
    d   = (w.day_in == 0) ? int'(c.today_day) : int'(w.day_in);
    m   = (w.month_in == 0) ? int'(c.today_month) : int'(w.month_in);
    y   = (w.year_in == 0) ? int'(c.today_year) : int'(w.year_in);
    off = int'($signed(w.day_offset));
    st  = StatOk;
    if (y < lo || y > hi) begin
      st = StatYearLim;
    end else if (d == 0 || d > 31) begin
      st = StatBadDay;
    end else if (m == 0 || m > 12) begin
      st = StatBadMonth;
    end else if (lens_max[m - 1] < d) begin
      st = StatPastEnd;
    end else if (m == 2 && d == 29 && !leap_year(y)) begin
      st = StatNotLeap;
    end
    if (st == StatOk) begin
      day = d + off;
      mon = m;
      yr  = y;
      while (day <= 0) begin
        if (mon == 1) begin
          mon = 12;
          yr--;
        end else begin
          mon--;
        end
        day += days_in(mon, yr);
      end
      while (day > days_in(mon, yr)) begin
        day -= days_in(mon, yr);
        if (mon == 12) begin
          mon = 1;
          yr++;
        end else begin
          mon++;
        end
      end
      if (yr < lo || yr > hi) begin
        st = StatOutRange;
      end else begin
        r.day_out   = day[4:0];
        r.month_out = mon[3:0];
        r.year_out  = yr[YearW-1:0];
      end
    end
    r.status = st;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.min_year    = 12'd1902;
      cfg.max_year    = 12'd2037;
      cfg.today_day   = 5'd1;
      cfg.today_month = 4'd1;
      cfg.today_year  = 12'd2000;
      expected_q.delete();
      errors  = 0;
      checked = 0;
      pending = 0;
    end else begin
      if (valid_o) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected: %p", out_o);
          errors++;
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (out_o.day_out !== want.day_out) begin
            $error("day_out expected %0d got %0d", want.day_out, out_o.day_out);
            errors++;
          end
          if (out_o.month_out !== want.month_out) begin
            $error("month_out expected %0d got %0d", want.month_out, out_o.month_out);
            errors++;
          end
          if (out_o.year_out !== want.year_out) begin
            $error("year_out expected %0d got %0d", want.year_out, out_o.year_out);
            errors++;
          end
          if (out_o.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_o.status);
            errors++;
          end
        end
      end
      if (start_i && !busy_o) begin
        expected_q.push_back(date_result(in_i, cfg));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMinYear:    cfg.min_year    = cfg_wdata_i;
          CfgMaxYear:    cfg.max_year    = cfg_wdata_i;
          CfgTodayDay:   cfg.today_day   = cfg_wdata_i[4:0];
          CfgTodayMonth: cfg.today_month = cfg_wdata_i[3:0];
          CfgTodayYear:  cfg.today_year  = cfg_wdata_i;
          default: ;
        endcase
      end
      pending = expected_q.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
// Testbench top: drives date words and register writes into the date adder and gives the verdict.
module testbench;
  import dvad_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  in_t                 in_i;
  logic                valid_o;
  out_t                out_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  int errors, pending, checked;
  int words_sent;
  int settings;
  int gen_lo = 1902;
  int gen_hi = 2037;

  date_validate_and_add_days DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .valid_o    (valid_o),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  date_result_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .valid_o    (valid_o),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic in_t date_word(input int d, input int m, input int y, input int off);
    in_t w;
    w.day_in     = 5'(d);
    w.month_in   = 4'(m);
    w.year_in    = YearW'(y);
    w.day_offset = OffsetBits'(off);
    return w;
  endfunction

  // mostly well-formed dates inside the current limits, some raw noise
  function automatic in_t rand_date();
    in_t w;
    int mon;
    int top_day;
    w.day_in     = 5'($urandom);
    w.month_in   = 4'($urandom);
    w.year_in    = YearW'($urandom);
    w.day_offset = OffsetBits'($urandom);
    if ($urandom_range(99) >= 12) begin
      mon = $urandom_range(12, 1);
      top_day = (mon == 2) ? 29 : (mon == 4 || mon == 6 || mon == 9 || mon == 11) ? 30 : 31;
      w.month_in = 4'(mon);
      w.day_in   = 5'(($urandom_range(9) == 0) ? top_day : $urandom_range(top_day - 1, 1));
      w.year_in  = YearW'((gen_lo <= gen_hi) ? $urandom_range(gen_hi, gen_lo) : $urandom);
      if ($urandom_range(99) < 60) begin
        w.day_offset = OffsetBits'(int'($urandom_range(2000)) - 1000);
      end else if ($urandom_range(29) == 0) begin
        w.day_offset = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      end
      if ($urandom_range(19) == 0) w.day_in = 0;
      if ($urandom_range(19) == 0) w.month_in = 0;
      if ($urandom_range(19) == 0) w.year_in = 0;
    end
    return w;
  endfunction

  // start stays high on return so back-to-back words need no extra edge
  task automatic send_date(input in_t w);
    @(negedge clk_i);
    start_i <= 1'b1;
    in_i    <= w;
    do @(posedge clk_i); while (busy_o);
    words_sent++;
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
  endtask

  task automatic set_config(input logic [CfgDataW-1:0] lo, input logic [CfgDataW-1:0] hi,
                            input logic [CfgDataW-1:0] td, input logic [CfgDataW-1:0] tm,
                            input logic [CfgDataW-1:0] ty);
    drain();
    // unmapped indexes must be ignored
    for (int i = int'(CfgTodayYear) + 1; i < (1 << CfgIdxW); i++) begin
      put_reg(CfgIdxW'(i), CfgDataW'($urandom));
    end
    put_reg(CfgMinYear, lo);
    put_reg(CfgMaxYear, hi);
    put_reg(CfgTodayDay, td);
    put_reg(CfgTodayMonth, tm);
    put_reg(CfgTodayYear, ty);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    gen_lo = lo;
    gen_hi = hi;
    settings++;
  endtask

  initial begin
    int lo, hi, td, tm, ty;
    int burst;
    start_i     = 1'b0;
    in_i        = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgMinYear;
    cfg_wdata_i = '0;
    words_sent  = 0;
    settings    = 1;
    rst_ni      = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset limits 1902..2037, today 1 Jan 2000
    send_date(date_word(0, 0, 0, 0));
    send_date(date_word(29, 2, 2000, 0));
    send_date(date_word(29, 2, 2001, 0));
    send_date(date_word(31, 4, 2001, 0));
    send_date(date_word(30, 2, 2004, 0));
    send_date(date_word(31, 13, 2001, 0));
    send_date(date_word(1, 1, 1901, 0));
    send_date(date_word(1, 1, 2038, 0));
    send_date(date_word(31, 12, 2037, 1));
    send_date(date_word(1, 1, 1902, -1));
    send_date(date_word(28, 2, 1999, 1));
    send_date(date_word(1, 3, 2000, -1));
    send_date(date_word(1, 1, 1950, 32767));
    send_date(date_word(31, 12, 2030, -32768));

    // full year range; today_day masks to zero, today_month zero
    set_config(12'd0, 12'd4095, 12'hFE0, 12'd0, 12'd4095);
    send_date(date_word(0, 5, 2000, 0));
    send_date(date_word(10, 0, 2000, 0));
    send_date(date_word(29, 2, 1900, 0));
    send_date(date_word(29, 2, 2100, 0));
    send_date(date_word(29, 2, 2400, 0));
    send_date(date_word(28, 2, 2100, 1));
    send_date(date_word(1, 1, 0, 0));
    send_date(date_word(1, 1, 1, -32768));
    send_date(date_word(31, 12, 4095, 32767));

    set_config(12'd0, 12'd4095, 12'd31, 12'd15, 12'd0);
    send_date(date_word(0, 0, 0, 0));
    send_date(date_word(29, 2, 0, 0));
    send_date(date_word(0, 12, 0, 0));

    // inverted limits
    set_config(12'd3000, 12'd100, 12'd1, 12'd1, 12'd2000);
    send_date(date_word(1, 1, 2000, 0));
    send_date(date_word(1, 1, 3000, 0));

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          lo = 0;
          hi = 4095;
        end
        1: begin
          lo = 1902;
          hi = 2037;
        end
        2: begin
          lo = $urandom_range(3000);
          hi = lo + $urandom_range(4095 - lo);
        end
        3: begin
          lo = $urandom_range(4095);
          hi = lo;
        end
        default: begin
          lo = $urandom_range(2000);
          hi = $urandom_range(4095, lo);
        end
      endcase
      td = (p == 4) ? $urandom_range(31) : $urandom_range(28, 1);
      tm = (p == 4) ? $urandom_range(15) : $urandom_range(12, 1);
      ty = $urandom_range(hi, lo);
      set_config(CfgDataW'(lo), CfgDataW'(hi), CfgDataW'(td), CfgDataW'(tm), CfgDataW'(ty));
      burst = $urandom_range(40, 1);
      for (int i = 0; i < 100; i++) begin
        if (burst == 0) begin
          pause($urandom_range(30, 1));
          burst = $urandom_range(40, 1);
        end
        send_date(rand_date());
        burst--;
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("%0d date words sent over %0d register settings, %0d results checked",
             words_sent, settings, checked);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dvad_pkg.sv
rtl/dvad_cfg.sv
rtl/dvad_ctrl.sv
rtl/dvad_dp.sv
rtl/date_validate_and_add_days.sv
rtl/dvad_checker.sv
test/date_result_checker.sv
test/testbench.sv
